### hdl/assert_macros.svh
// Assertion helpers. Each macro samples on clk and stays quiet while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check b in the same cycle as a.
`define ASSERT_SAME(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error("assertion failed: same-cycle implication");

// Check b in the cycle after a.
`define ASSERT_NEXT(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_SAME(lbl, a, b)
`define ASSERT_NEXT(lbl, a, b)

`endif

`endif

### hdl/tcgr_pkg.sv
package tcgr_pkg;

	localparam int GLYPH_HEIGHT = 16;
	localparam int ROW_IDX_W    = 4;
	localparam int OFFSET_W     = 25;
	localparam int COLOR_W      = 32;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 32;

	localparam logic [ROW_IDX_W-1:0] ROW_IDX_LAST = ROW_IDX_W'(GLYPH_HEIGHT - 1);

	// input commands
	localparam logic CMD_PUTC = 1'b0;
	localparam logic CMD_FONT = 1'b1;

	// result kinds
	localparam logic KIND_GLYPH  = 1'b0;
	localparam logic KIND_SCROLL = 1'b1;

	// control characters
	localparam logic [7:0] CHAR_NUL = 8'h00;
	localparam logic [7:0] CHAR_TAB = 8'h09;
	localparam logic [7:0] CHAR_NL  = 8'h0A;
	localparam logic [7:0] CHAR_CR  = 8'h0D;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_COLUMNS     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_PITCH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WIDE_PIXELS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GLYPH_COLOR = 3'd4;

	localparam logic [8:0]  RST_COLUMNS     = 9'd80;
	localparam logic [7:0]  RST_ROWS        = 8'd25;
	localparam logic [14:0] RST_LINE_PITCH  = 15'd2560;
	localparam logic        RST_WIDE_PIXELS = 1'b1;
	localparam logic [31:0] RST_GLYPH_COLOR = 32'd12632256;

	// item classes seen by the controller
	localparam logic [2:0] CLS_NUL   = 3'd0;
	localparam logic [2:0] CLS_CR    = 3'd1;
	localparam logic [2:0] CLS_NL    = 3'd2;
	localparam logic [2:0] CLS_TAB   = 3'd3;
	localparam logic [2:0] CLS_PRINT = 3'd4;
	localparam logic [2:0] CLS_FONT  = 3'd5;

	typedef struct packed {
		logic                 font_wr;
		logic                 load_acc;
		logic                 col_clear;
		logic                 col_tab;
		logic                 col_inc;
		logic                 row_inc;
		logic                 row_last;
		logic                 issue;
		logic                 issue_kind;
		logic                 issue_last;
		logic [ROW_IDX_W-1:0] row_idx;
	} ctl_cmd_t;

	typedef struct packed {
		logic [2:0] cls;
		logic       wrap_col;
		logic       wrap_tab;
		logic       wrap_row;
		logic       issue_ok;
	} dp_sts_t;

endpackage

### hdl/tcgr_ctrl.sv
module tcgr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               busy,
	input  tcgr_pkg::dp_sts_t  sts,
	output tcgr_pkg::ctl_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_ROWS   = 2'd1;
	localparam logic [1:0] ST_SCROLL = 2'd2;

	logic [1:0]                     state_q, state_d;
	logic [tcgr_pkg::ROW_IDX_W-1:0] row_q, row_d;

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		cmd        = '0;
		state_d    = state_q;
		row_d      = row_q;
		cmd.row_idx = row_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (sts.cls)
						tcgr_pkg::CLS_FONT: cmd.font_wr = 1'b1;
						tcgr_pkg::CLS_CR:   cmd.col_clear = 1'b1;
						tcgr_pkg::CLS_NL: begin
							cmd.col_clear = 1'b1;
							if (sts.wrap_row) begin
								cmd.row_last = 1'b1;
								state_d      = ST_SCROLL;
							end else begin
								cmd.row_inc = 1'b1;
							end
						end
						tcgr_pkg::CLS_TAB: begin
							if (sts.wrap_tab) begin
								cmd.col_clear = 1'b1;
								if (sts.wrap_row) begin
									cmd.row_last = 1'b1;
									state_d      = ST_SCROLL;
								end else begin
									cmd.row_inc = 1'b1;
								end
							end else begin
								cmd.col_tab = 1'b1;
							end
						end
						tcgr_pkg::CLS_PRINT: begin
							cmd.load_acc = 1'b1;
							row_d        = '0;
							state_d      = ST_ROWS;
						end
						default: ;
					endcase
				end
			end
			ST_ROWS: begin
				if (sts.issue_ok) begin
					cmd.issue      = 1'b1;
					cmd.issue_kind = tcgr_pkg::KIND_GLYPH;
					cmd.issue_last = (row_q == tcgr_pkg::ROW_IDX_LAST) &&
						!(sts.wrap_col && sts.wrap_row);
					row_d = row_q + tcgr_pkg::ROW_IDX_W'(1);
					if (row_q == tcgr_pkg::ROW_IDX_LAST) begin
						state_d = ST_IDLE;
						if (sts.wrap_col) begin
							cmd.col_clear = 1'b1;
							if (sts.wrap_row) begin
								cmd.row_last = 1'b1;
								state_d      = ST_SCROLL;
							end else begin
								cmd.row_inc = 1'b1;
							end
						end else begin
							cmd.col_inc = 1'b1;
						end
					end
				end
			end
			ST_SCROLL: begin
				if (sts.issue_ok) begin
					cmd.issue      = 1'b1;
					cmd.issue_kind = tcgr_pkg::KIND_SCROLL;
					cmd.issue_last = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q   <= '0;
		end else begin
			state_q <= state_d;
			row_q   <= row_d;
		end
	end

endmodule

### hdl/tcgr_datapath.sv
module tcgr_datapath #(
	parameter int GLYPH_COUNT = 256
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  tcgr_pkg::ctl_cmd_t                   cmd_c,
	output tcgr_pkg::dp_sts_t                    sts,
	input  logic                                 cfg_valid,
	input  logic [tcgr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tcgr_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 cmd,
	input  logic [7:0]                           char_code,
	input  logic [11:0]                          font_index,
	input  logic [7:0]                           font_byte,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 kind,
	output logic [tcgr_pkg::OFFSET_W-1:0]        byte_offset,
	output logic [7:0]                           row_bits,
	output logic [tcgr_pkg::COLOR_W-1:0]         color,
	output logic                                 last
);

	localparam int FONT_DEPTH = GLYPH_COUNT * tcgr_pkg::GLYPH_HEIGHT;
	localparam int AW         = $clog2(FONT_DEPTH);
	localparam int GW         = AW - tcgr_pkg::ROW_IDX_W;

	logic [7:0] font_mem [FONT_DEPTH];

	logic [8:0]  columns_q;
	logic [7:0]  rows_q;
	logic [14:0] line_pitch_q;
	logic        wide_pixels_q;
	logic [31:0] glyph_color_q;

	logic [8:0]  col_q;
	logic [6:0]  row_q;
	logic [GW-1:0] glyph_q;
	logic [tcgr_pkg::OFFSET_W-1:0] acc_q;

	logic                          valid_s1;
	logic                          kind_s1;
	logic                          last_s1;
	logic [tcgr_pkg::OFFSET_W-1:0] off_s1;
	logic [7:0]                    rdata_s1;

	logic                          out_v_q;
	logic                          kind_q;
	logic                          last_q;
	logic [tcgr_pkg::OFFSET_W-1:0] off_q;
	logic [7:0]                    bits_q;
	logic [31:0]                   color_q;

	logic [8:0]  ecols;
	logic [7:0]  erows;
	logic [7:0]  erows_m1;
	logic [9:0]  col_p1, col_tab;
	logic [7:0]  row_p1;
	logic [8:0]  ch_ext, glyph_full;
	logic [10:0] line0;
	logic [25:0] prod;
	logic [13:0] base;
	logic        out_free, move;

	// effective screen size
	always_comb begin
		if (columns_q == 9'd0)        ecols = 9'd1;
		else if (columns_q > 9'd256)  ecols = 9'd256;
		else                          ecols = columns_q;
		if (rows_q == 8'd0)           erows = 8'd1;
		else if (rows_q > 8'd128)     erows = 8'd128;
		else                          erows = rows_q;
	end

	assign erows_m1 = erows - 8'd1;
	assign col_p1   = {1'b0, col_q} + 10'd1;
	assign col_tab  = {1'b0, col_q[8:3], 3'b000} + 10'd8;
	assign row_p1   = {1'b0, row_q} + 8'd1;

	assign ch_ext     = {1'b0, char_code};
	assign glyph_full = (ch_ext >= 9'(GLYPH_COUNT)) ? ch_ext - 9'(GLYPH_COUNT) : ch_ext;

	assign line0 = {row_q, 4'b0000};
	assign prod  = {15'd0, line0} * {11'd0, line_pitch_q};
	assign base  = wide_pixels_q ? {col_q, 5'b00000} : {1'b0, col_q, 4'b0000};

	assign out_free = !out_v_q || !out_stall;
	assign move     = valid_s1 && out_free;

	always_comb begin
		if (cmd == tcgr_pkg::CMD_FONT) begin
			sts.cls = tcgr_pkg::CLS_FONT;
		end else begin
			case (char_code)
				tcgr_pkg::CHAR_NUL: sts.cls = tcgr_pkg::CLS_NUL;
				tcgr_pkg::CHAR_TAB: sts.cls = tcgr_pkg::CLS_TAB;
				tcgr_pkg::CHAR_NL:  sts.cls = tcgr_pkg::CLS_NL;
				tcgr_pkg::CHAR_CR:  sts.cls = tcgr_pkg::CLS_CR;
				default:            sts.cls = tcgr_pkg::CLS_PRINT;
			endcase
		end
		sts.wrap_col = (col_p1 >= {1'b0, ecols});
		sts.wrap_tab = (col_tab >= {1'b0, ecols});
		sts.wrap_row = (row_p1 >= erows);
		sts.issue_ok = !valid_s1 || move;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q     <= tcgr_pkg::RST_COLUMNS;
			rows_q        <= tcgr_pkg::RST_ROWS;
			line_pitch_q  <= tcgr_pkg::RST_LINE_PITCH;
			wide_pixels_q <= tcgr_pkg::RST_WIDE_PIXELS;
			glyph_color_q <= tcgr_pkg::RST_GLYPH_COLOR;
		end else if (cfg_valid) begin
			case (cfg_index)
				tcgr_pkg::REG_COLUMNS:     columns_q     <= cfg_data[8:0];
				tcgr_pkg::REG_ROWS:        rows_q        <= cfg_data[7:0];
				tcgr_pkg::REG_LINE_PITCH:  line_pitch_q  <= cfg_data[14:0];
				tcgr_pkg::REG_WIDE_PIXELS: wide_pixels_q <= cfg_data[0];
				tcgr_pkg::REG_GLYPH_COLOR: glyph_color_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else begin
			if (cmd_c.col_clear)    col_q <= '0;
			else if (cmd_c.col_tab) col_q <= col_tab[8:0];
			else if (cmd_c.col_inc) col_q <= col_p1[8:0];
			if (cmd_c.row_last)     row_q <= erows_m1[6:0];
			else if (cmd_c.row_inc) row_q <= row_p1[6:0];
		end
	end

	// glyph number and running row offset
	always_ff @(posedge clk) begin
		if (cmd_c.load_acc) begin
			glyph_q <= glyph_full[GW-1:0];
			acc_q   <= prod[tcgr_pkg::OFFSET_W-1:0] + {11'd0, base};
		end else if (cmd_c.issue && cmd_c.issue_kind == tcgr_pkg::KIND_GLYPH) begin
			acc_q <= acc_q + {10'd0, line_pitch_q};
		end
	end

	// font store
	always_ff @(posedge clk) begin
		if (cmd_c.font_wr && ({1'b0, font_index} < 13'(FONT_DEPTH)))
			font_mem[font_index[AW-1:0]] <= font_byte;
		if (cmd_c.issue && cmd_c.issue_kind == tcgr_pkg::KIND_GLYPH)
			rdata_s1 <= font_mem[{glyph_q, cmd_c.row_idx}];
	end

	// fetch stage and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (cmd_c.issue)   valid_s1 <= 1'b1;
			else if (move)     valid_s1 <= 1'b0;
			if (move)          out_v_q <= 1'b1;
			else if (out_free) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_c.issue) begin
			kind_s1 <= cmd_c.issue_kind;
			last_s1 <= cmd_c.issue_last;
			off_s1  <= acc_q;
		end
		if (move) begin
			kind_q  <= kind_s1;
			last_q  <= last_s1;
			off_q   <= (kind_s1 == tcgr_pkg::KIND_SCROLL) ? '0 : off_s1;
			bits_q  <= (kind_s1 == tcgr_pkg::KIND_SCROLL) ? 8'd0 : rdata_s1;
			color_q <= (kind_s1 == tcgr_pkg::KIND_SCROLL) ? 32'd0 : glyph_color_q;
		end
	end

	assign out_valid   = out_v_q;
	assign kind        = kind_q;
	assign last        = last_q;
	assign byte_offset = off_q;
	assign row_bits    = bits_q;
	assign color       = color_q;

endmodule

### hdl/text_console_glyph_renderer.sv
// Text console glyph renderer with an 8x16 font store and a text cursor.
// Input channel (in_valid / in_stall, fields cmd, char_code, font_index, font_byte):
// a font load writes one byte of the font store; CR, newline and tab only move the
// cursor, and newline or tab may also produce a scroll request; NUL is ignored. A
// printable character is accepted with its first row offset formed by one
// multiply-add, then its 16 glyph rows are read in order through the single read
// port of the font store, pausing while the result path is full; a scroll request
// follows when the cursor wrap also scrolls. Another item is taken once the last
// read or scroll request of the previous one has been issued.
// Output channel (out_valid / out_stall): one transaction per glyph row write or
// scroll request, with last marking the final result of an item. Each row passes
// through a read stage and an output register, so a stalled receiver holds the
// output while one more row waits.
// Configuration port (cfg_valid / cfg_ready, cfg_index, cfg_data): always ready;
// write only while the block is idle and all results have been taken.
// Reset clears the cursor to column 0, row 0, restores the register defaults and
// empties the result path. The font store is not cleared: load it before printing.
module text_console_glyph_renderer #(
	parameter int GLYPH_COUNT = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             cmd,
	input  logic [7:0]                       char_code,
	input  logic [11:0]                      font_index,
	input  logic [7:0]                       font_byte,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             kind,
	output logic [tcgr_pkg::OFFSET_W-1:0]    byte_offset,
	output logic [7:0]                       row_bits,
	output logic [tcgr_pkg::COLOR_W-1:0]     color,
	output logic                             last,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [tcgr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tcgr_pkg::CFG_DATA_W-1:0]  cfg_data
);

	`include "assert_macros.svh"

	tcgr_pkg::ctl_cmd_t cmd_w;
	tcgr_pkg::dp_sts_t  sts_w;
	logic               busy;

	// registers take a write in any cycle
	assign cfg_ready = 1'b1;
	// hold the input side while a character's rows or a scroll are in flight
	assign in_stall  = busy;

	tcgr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.busy     (busy),
		.sts      (sts_w),
		.cmd      (cmd_w)
	);

	tcgr_datapath #(
		.GLYPH_COUNT (GLYPH_COUNT)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_c       (cmd_w),
		.sts         (sts_w),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cmd         (cmd),
		.char_code   (char_code),
		.font_index  (font_index),
		.font_byte   (font_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.byte_offset (byte_offset),
		.row_bits    (row_bits),
		.color       (color),
		.last        (last)
	);

	// a read is only issued when the fetch stage has room
	`ASSERT_SAME(a_issue_room, cmd_w.issue, sts_w.issue_ok)
	// a scroll request always closes its item
	`ASSERT_SAME(a_scroll_last, cmd_w.issue && cmd_w.issue_kind == tcgr_pkg::KIND_SCROLL, cmd_w.issue_last)
	// a printable character blocks the input side while its rows are read
	`ASSERT_NEXT(a_print_busy, cmd_w.load_acc, in_stall)

endmodule
